@@ hw/rtl/dmrc_pkg.sv @@
`timescale 1ns / 1ps

package dmrc_pkg;

   // table geometry
   localparam int unsigned ENTRIES  = 1024;
   localparam int unsigned IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam bit          IS_POW2  = ((ENTRIES & (ENTRIES - 1)) == 0);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(ENTRIES - 1);

   // field widths
   localparam int unsigned TYPE_W = 3;
   localparam int unsigned KEY_W  = 64;
   localparam int unsigned VAL_W  = 32;
   localparam int unsigned QUAL_W = 16;
   localparam int unsigned AGE_W  = 8;

   // with a power-of-two table the slot bits are implied by the address
   localparam int unsigned TAG_W = IS_POW2 ? KEY_W - IDX_W : KEY_W;

   localparam logic [AGE_W-1:0] AGE_TOP       = '1;
   localparam logic [AGE_W-1:0] MAX_AGE_RESET = AGE_W'(8);

   // command queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [TYPE_W-1:0] {
      REQ_LOOKUP     = 3'd0,
      REQ_LOOKUP_MIN = 3'd1,
      REQ_UPDATE     = 3'd2,
      REQ_SET        = 3'd3,
      REQ_SWEEP      = 3'd4
   } req_code_type;

   typedef enum logic [2:0] {
      OP_LOOKUP,
      OP_LOOKUP_MIN,
      OP_UPDATE,
      OP_SET,
      OP_SWEEP,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic [IDX_W-1:0]         slot;
      logic [TAG_W-1:0]         tag;
      logic [VAL_W-1:0]         value;
      logic signed [QUAL_W-1:0] new_quality;
      logic signed [QUAL_W-1:0] min_quality;
   } cmd_type;

   typedef struct packed {
      logic                     valid;
      logic [TAG_W-1:0]         tag;
      logic [VAL_W-1:0]         value;
      logic signed [QUAL_W-1:0] quality;
      logic [AGE_W-1:0]         age;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

   function automatic op_type classify(input logic [TYPE_W-1:0] code);
      op_type op;
      case (code)
         REQ_LOOKUP:     op = OP_LOOKUP;
         REQ_LOOKUP_MIN: op = OP_LOOKUP_MIN;
         REQ_UPDATE:     op = OP_UPDATE;
         REQ_SET:        op = OP_SET;
         REQ_SWEEP:      op = OP_SWEEP;
         default:        op = OP_NONE;
      endcase
      return op;
   endfunction

endpackage

@@ hw/rtl/dmrc_ram.sv @@
`timescale 1ns / 1ps

module dmrc_ram #(
   parameter int unsigned WIDTH  = 8,
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/dmrc_queue.sv @@
`timescale 1ns / 1ps

module dmrc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  dmrc_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output dmrc_pkg::cmd_type pop_data
);

   import dmrc_pkg::*;

   localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [QPTR_W-1:0] QPTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(QUEUE_DEPTH);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != QCNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_LAST) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_LAST) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hw/rtl/dmrc_front.sv @@
`timescale 1ns / 1ps

module dmrc_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               clearing,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [dmrc_pkg::TYPE_W-1:0]        req_type,
   input  logic [dmrc_pkg::KEY_W-1:0]         req_fingerprint,
   input  logic [dmrc_pkg::VAL_W-1:0]         req_new_value,
   input  logic signed [dmrc_pkg::QUAL_W-1:0] req_new_quality,
   input  logic signed [dmrc_pkg::QUAL_W-1:0] req_min_quality,
   output logic                               push_valid,
   input  logic                               push_ready,
   output dmrc_pkg::cmd_type                  push_data
);

   import dmrc_pkg::*;

   if (IS_POW2) begin : g_mask
      // slot is the low address bits, tag the rest
      assign req_ready = push_ready && !clearing;
      assign push_valid = req_valid && !clearing;

      always_comb begin
         push_data.op          = classify(req_type);
         push_data.slot        = req_fingerprint[IDX_W-1:0];
         push_data.tag         = req_fingerprint[KEY_W-1:IDX_W];
         push_data.value       = req_new_value;
         push_data.new_quality = req_new_quality;
         push_data.min_quality = req_min_quality;
      end

      logic unused_clk;
      assign unused_clk = clock ^ reset;
   end else begin : g_rem
      // remainder by the table size, one key bit per step, eight steps a cycle
      localparam int unsigned BITS_PER_CYC = 8;
      localparam int unsigned STEPS        = KEY_W / BITS_PER_CYC;
      localparam int unsigned STEP_W       = $clog2(STEPS + 1);
      localparam logic [STEP_W-1:0] STEP_DONE = STEP_W'(STEPS);
      localparam logic [IDX_W:0]    MODULUS   = (IDX_W + 1)'(ENTRIES);

      logic              busy_ff, busy_in;
      logic [STEP_W-1:0] step_ff, step_in;
      logic [IDX_W-1:0]  rem_ff, rem_in;
      logic [KEY_W-1:0]  shift_ff, shift_in;
      cmd_type           hold_ff, hold_in;
      logic              accept;

      assign req_ready = !busy_ff && !clearing;
      assign accept    = req_valid && req_ready;

      always_comb begin
         logic [IDX_W:0]   r2;
         logic [IDX_W-1:0] r;
         busy_in  = busy_ff;
         step_in  = step_ff;
         rem_in   = rem_ff;
         shift_in = shift_ff;
         hold_in  = hold_ff;
         push_valid = 1'b0;
         push_data  = hold_ff;
         push_data.slot = rem_ff;
         r = rem_ff;
         for (int b = 0; b < BITS_PER_CYC; b++) begin
            r2 = {r, shift_ff[KEY_W-1-b]};
            if (r2 >= MODULUS) begin
               r2 = r2 - MODULUS;
            end
            r = r2[IDX_W-1:0];
         end
         if (accept) begin
            busy_in  = 1'b1;
            step_in  = '0;
            rem_in   = '0;
            shift_in = req_fingerprint;
            hold_in.op          = classify(req_type);
            hold_in.slot        = '0;
            hold_in.tag         = req_fingerprint;
            hold_in.value       = req_new_value;
            hold_in.new_quality = req_new_quality;
            hold_in.min_quality = req_min_quality;
         end else if (busy_ff && step_ff != STEP_DONE) begin
            rem_in   = r;
            shift_in = shift_ff << BITS_PER_CYC;
            step_in  = step_ff + STEP_W'(1);
         end else if (busy_ff) begin
            push_valid = 1'b1;
            if (push_ready) begin
               busy_in = 1'b0;
            end
         end
      end

      always_ff @(posedge clock) begin
         step_ff  <= step_in;
         rem_ff   <= rem_in;
         shift_ff <= shift_in;
         hold_ff  <= hold_in;
         if (reset) begin
            busy_ff <= 1'b0;
         end else begin
            busy_ff <= busy_in;
         end
      end
   end

endmodule

@@ hw/rtl/dmrc_back.sv @@
`timescale 1ns / 1ps

module dmrc_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [dmrc_pkg::AGE_W-1:0]         max_age,
   input  logic                               cmd_valid,
   output logic                               cmd_ready,
   input  dmrc_pkg::cmd_type                  cmd_data,
   output logic                               clearing,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_hit,
   output logic [dmrc_pkg::VAL_W-1:0]         rsp_stored_value,
   output logic signed [dmrc_pkg::QUAL_W-1:0] rsp_stored_quality,
   output logic                               rsp_written
);

   import dmrc_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP
   } state_type;

   state_type               state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [IDX_W-1:0]        addr_ff, addr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic [VAL_W-1:0]        rsp_value_ff, rsp_value_in;
   logic signed [QUAL_W-1:0] rsp_quality_ff, rsp_quality_in;
   logic                    rsp_written_ff, rsp_written_in;

   logic                    ram_we, ram_re;
   logic [IDX_W-1:0]        ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0]      ram_wdata, ram_rdata;

   entry_type               rd_entry, new_entry, aged_entry;
   logic                    out_free, match, keep;
   logic [AGE_W-1:0]        age_inc;

   dmrc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_entry = entry_type'(ram_rdata);
   assign match    = rd_entry.valid && (rd_entry.tag == cmd_ff.tag);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      new_entry.valid   = 1'b1;
      new_entry.tag     = cmd_ff.tag;
      new_entry.value   = cmd_ff.value;
      new_entry.quality = cmd_ff.new_quality;
      new_entry.age     = '0;
      // saturating age step
      age_inc = (rd_entry.age == AGE_TOP) ? AGE_TOP : rd_entry.age + AGE_W'(1);
      keep    = (age_inc <= max_age);
      aged_entry       = rd_entry;
      aged_entry.age   = age_inc;
      aged_entry.valid = keep;
   end

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      addr_in        = addr_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_quality_in = rsp_quality_ff;
      rsp_written_in = rsp_written_ff;
      cmd_ready      = 1'b0;
      ram_re         = 1'b0;
      ram_raddr      = addr_ff;
      ram_we         = 1'b0;
      ram_waddr      = addr_ff;
      ram_wdata      = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            if (addr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
         end
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_ready = 1'b1;
               cmd_in    = cmd_data;
               ram_re    = 1'b1;
               if (cmd_data.op == OP_SWEEP) begin
                  ram_raddr = '0;
                  addr_in   = '0;
                  state_in  = ST_SWEEP;
               end else begin
                  ram_raddr = cmd_data.slot;
                  state_in  = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            rsp_valid_in   = 1'b1;
            rsp_hit_in     = 1'b0;
            rsp_value_in   = '0;
            rsp_quality_in = '0;
            rsp_written_in = 1'b0;
            ram_waddr      = cmd_ff.slot;
            case (cmd_ff.op)
               OP_LOOKUP, OP_LOOKUP_MIN: begin
                  if (match) begin
                     // a match refreshes the age even when quality is too low
                     ram_we        = 1'b1;
                     ram_wdata     = rd_entry;
                     ram_wdata[AGE_W-1:0] = '0;
                     if (cmd_ff.op == OP_LOOKUP ||
                         rd_entry.quality >= cmd_ff.min_quality) begin
                        rsp_hit_in     = 1'b1;
                        rsp_value_in   = rd_entry.value;
                        rsp_quality_in = rd_entry.quality;
                     end
                  end
               end
               OP_UPDATE: begin
                  if (!rd_entry.valid || cmd_ff.new_quality >= rd_entry.quality) begin
                     ram_we         = 1'b1;
                     ram_wdata      = new_entry;
                     rsp_written_in = 1'b1;
                  end
               end
               OP_SET: begin
                  ram_we         = 1'b1;
                  ram_wdata      = new_entry;
                  rsp_written_in = 1'b1;
               end
               default: begin
               end
            endcase
            state_in = ST_IDLE;
         end
         ST_SWEEP: begin
            // data of addr_ff is back, write it aged while the next one is read
            ram_we    = rd_entry.valid;
            ram_wdata = aged_entry;
            if (addr_ff == LAST_SLOT) begin
               rsp_valid_in   = 1'b1;
               rsp_hit_in     = 1'b0;
               rsp_value_in   = '0;
               rsp_quality_in = '0;
               rsp_written_in = 1'b0;
               state_in       = ST_IDLE;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = addr_ff + IDX_W'(1);
               addr_in   = addr_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_quality_ff <= rsp_quality_in;
      rsp_written_ff <= rsp_written_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign clearing           = (state_ff == ST_CLEAR);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_stored_value   = rsp_value_ff;
   assign rsp_stored_quality = rsp_quality_ff;
   assign rsp_written        = rsp_written_ff;

endmodule

@@ hw/rtl/direct_mapped_result_cache_with_aging.sv @@
`timescale 1ns / 1ps
// a lookup, update or set passes the command queue, then one table read, then compare and
// write back into the response register; the back takes the next command only after the
// last one is written back, and only while the response register is free
// aging sweep: one entry read per cycle, each valid entry written back aged
// reset: synchronous; afterwards a clearing pass over all ENTRIES slots holds req_ready low,
// max_age returns to 8; csr writes are taken at any time
module direct_mapped_result_cache_with_aging (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [dmrc_pkg::TYPE_W-1:0]        req_type,
   input  logic [dmrc_pkg::KEY_W-1:0]         req_fingerprint,
   input  logic [dmrc_pkg::VAL_W-1:0]         req_new_value,
   input  logic signed [dmrc_pkg::QUAL_W-1:0] req_new_quality,
   input  logic signed [dmrc_pkg::QUAL_W-1:0] req_min_quality,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_hit,
   output logic [dmrc_pkg::VAL_W-1:0]         rsp_stored_value,
   output logic signed [dmrc_pkg::QUAL_W-1:0] rsp_stored_quality,
   output logic                               rsp_written,
   // max_age register write
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dmrc_pkg::AGE_W-1:0]         csr_wdata
);

   import dmrc_pkg::*;

   logic [AGE_W-1:0] age_limit_ff, age_limit_in;
   logic             clearing;
   logic             push_valid, push_ready;
   cmd_type          push_data;
   logic             pop_valid, pop_ready;
   cmd_type          pop_data;

   // register port never stalls
   assign csr_ready = 1'b1;

   always_comb begin
      age_limit_in = age_limit_ff;
      if (csr_valid && csr_ready) begin
         age_limit_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         age_limit_ff <= MAX_AGE_RESET;
      end else begin
         age_limit_ff <= age_limit_in;
      end
   end

   // front: takes requests, finds the slot and decodes the operation
   dmrc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .clearing        (clearing),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_fingerprint (req_fingerprint),
      .req_new_value   (req_new_value),
      .req_new_quality (req_new_quality),
      .req_min_quality (req_min_quality),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_data       (push_data)
   );

   // short command queue so front and back stall independently
   dmrc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back: table read-modify-write, aging sweep, clearing pass, response register
   dmrc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .max_age            (age_limit_ff),
      .cmd_valid          (pop_valid),
      .cmd_ready          (pop_ready),
      .cmd_data           (pop_data),
      .clearing           (clearing),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_stored_value   (rsp_stored_value),
      .rsp_stored_quality (rsp_stored_quality),
      .rsp_written        (rsp_written)
   );

endmodule

@@ hw/rtl/dmrc_checker.sv @@
`timescale 1ns / 1ps

module dmrc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_hit,
   input logic [dmrc_pkg::VAL_W-1:0]         rsp_stored_value,
   input logic signed [dmrc_pkg::QUAL_W-1:0] rsp_stored_quality,
   input logic                               rsp_written
);

   // a waiting item stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a waiting item keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_hit) && $stable(rsp_stored_value)
         && $stable(rsp_stored_quality) && $stable(rsp_written))
      else $error("response payload changed while stalled");

   // a miss reports zero value and quality
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_stored_value == '0 && rsp_stored_quality == '0)
      else $error("miss with nonzero payload");

   // a lookup hit never reports a write
   a_hit_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_written))
      else $error("hit and written both set");

   // table is being cleared right after reset, no requests taken
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("request taken during clearing pass");

endmodule

bind direct_mapped_result_cache_with_aging dmrc_checker u_checker (.*);
